FILE: rtl/lr_pkg.sv
// ============================================================================
// lr_pkg
// Shared types and constants for the line rasterizer.
// ============================================================================
package lr_pkg;

    // Default coordinate width; valid range 4 to 16.
    localparam int COORD_BITS_DEF = 12;

    // Item operation codes
    typedef enum logic [0:0] {
        OP_BEGIN   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

endpackage

FILE: rtl/line_rasterizer_top.sv
// ============================================================================
// line_rasterizer_top
// Integer Bresenham line rasterizer, all octants, one pixel per advance item.
// ============================================================================
// A begin item loads start and end points and returns no result. Each
// advance item returns one result: the current pixel with pixel_valid set,
// or all zeros when no line is active (finished or empty). The end point is
// never drawn; last flags the pixel just before it. Equal spans make y the
// major axis, and an error of exactly one half steps the minor axis.
// Throughput is one item per clock while the output side takes results.
// An item passes the input register and then the result register; while
// the output side stalls, an advance item waits in the input register.
// The line state update (one add, one compare, one subtract) sits between
// the two registers, so back-to-back advances chain through the state.
// ============================================================================
module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_pixel_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);

    // input register
    logic                  r_s1_valid;
    t_op                   r_s1_op;
    logic [COORD_BITS-1:0] r_s1_xs, r_s1_ys, r_s1_xe, r_s1_ye;

    // line state
    logic [COORD_BITS-1:0]        r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [COORD_BITS-1:0]        r_span_x, r_span_y;
    logic signed [COORD_BITS+1:0] r_err;
    logic                         r_x_down, r_y_down, r_active;

    // result register
    logic                  r_out_valid, r_pix_valid, r_last;
    logic [COORD_BITS-1:0] r_pix_x, r_pix_y;

    // setup / step outputs
    logic                         su_x_down, su_y_down, su_active;
    logic [COORD_BITS-1:0]        su_span_x, su_span_y;
    logic [COORD_BITS-1:0]        st_cur_x, st_cur_y;
    logic signed [COORD_BITS+1:0] st_err;
    logic                         st_done;

    logic in_acc;
    logic s2_adv;
    logic out_free;

    lr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .i_x_start (r_s1_xs),
        .i_y_start (r_s1_ys),
        .i_x_end   (r_s1_xe),
        .i_y_end   (r_s1_ye),
        .o_x_down  (su_x_down),
        .o_y_down  (su_y_down),
        .o_span_x  (su_span_x),
        .o_span_y  (su_span_y),
        .o_active  (su_active)
    );

    lr_step #(.COORD_BITS(COORD_BITS)) u_step (
        .i_cur_x  (r_cur_x),
        .i_cur_y  (r_cur_y),
        .i_tgt_x  (r_tgt_x),
        .i_tgt_y  (r_tgt_y),
        .i_span_x (r_span_x),
        .i_span_y (r_span_y),
        .i_err    (r_err),
        .i_x_down (r_x_down),
        .i_y_down (r_y_down),
        .o_cur_x  (st_cur_x),
        .o_cur_y  (st_cur_y),
        .o_err    (st_err),
        .o_done   (st_done)
    );

    // A begin item needs no result slot; an advance needs the result
    // register empty or being drained this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_adv     = r_s1_valid && ((r_s1_op == OP_BEGIN) || out_free);
    assign o_in_ready = !r_s1_valid || s2_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op <= t_op'(i_op);
            r_s1_xs <= i_x_start;
            r_s1_ys <= i_y_start;
            r_s1_xe <= i_x_end;
            r_s1_ye <= i_y_end;
        end
    end

    // line state: loaded on begin, stepped on advance of an active line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
            r_err    <= '0;
            r_x_down <= 1'b0;
            r_y_down <= 1'b0;
            r_active <= 1'b0;
        end else if (s2_adv) begin
            if (r_s1_op == OP_BEGIN) begin
                r_cur_x  <= r_s1_xs;
                r_cur_y  <= r_s1_ys;
                r_tgt_x  <= r_s1_xe;
                r_tgt_y  <= r_s1_ye;
                r_span_x <= su_span_x;
                r_span_y <= su_span_y;
                r_err    <= '0;
                r_x_down <= su_x_down;
                r_y_down <= su_y_down;
                r_active <= su_active;
            end else if (r_active) begin
                r_cur_x  <= st_cur_x;
                r_cur_y  <= st_cur_y;
                r_err    <= st_err;
                r_active <= !st_done;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv && (r_s1_op == OP_ADVANCE)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && (r_s1_op == OP_ADVANCE)) begin
            // inactive line: result of all zeros
            r_pix_valid <= r_active;
            r_pix_x     <= r_active ? r_cur_x : '0;
            r_pix_y     <= r_active ? r_cur_y : '0;
            r_last      <= r_active && st_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_pix_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_last        = r_last;

endmodule

FILE: rtl/lr_setup.sv
// ============================================================================
// lr_setup
// Line setup: step directions, absolute spans and empty-line check.
// ============================================================================
module lr_setup
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_x_down,
    output logic                  o_y_down,
    output logic [COORD_BITS-1:0] o_span_x,
    output logic [COORD_BITS-1:0] o_span_y,
    output logic                  o_active
);

    always_comb begin
        o_x_down = i_x_end < i_x_start;
        o_y_down = i_y_end < i_y_start;
        o_span_x = o_x_down ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        o_span_y = o_y_down ? (i_y_start - i_y_end) : (i_y_end - i_y_start);
        o_active = (o_span_x != '0) || (o_span_y != '0);
    end

endmodule

FILE: rtl/lr_step.sv
// ============================================================================
// lr_step
// One Bresenham step: error update, minor and major axis moves, end check.
// ============================================================================
module lr_step
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]        i_cur_x,
    input  logic [COORD_BITS-1:0]        i_cur_y,
    input  logic [COORD_BITS-1:0]        i_tgt_x,
    input  logic [COORD_BITS-1:0]        i_tgt_y,
    input  logic [COORD_BITS-1:0]        i_span_x,
    input  logic [COORD_BITS-1:0]        i_span_y,
    input  logic signed [COORD_BITS+1:0] i_err,
    input  logic                         i_x_down,
    input  logic                         i_y_down,
    output logic [COORD_BITS-1:0]        o_cur_x,
    output logic [COORD_BITS-1:0]        o_cur_y,
    output logic signed [COORD_BITS+1:0] o_err,
    output logic                         o_done
);

    logic                         x_major;
    logic [COORD_BITS-1:0]        major;
    logic [COORD_BITS-1:0]        minor;
    logic signed [COORD_BITS+2:0] e_sum;
    logic signed [COORD_BITS+2:0] e_next;
    logic                         minor_step;
    logic [COORD_BITS-1:0]        x_moved;
    logic [COORD_BITS-1:0]        y_moved;

    always_comb begin
        // equal spans make y the major axis
        x_major = i_span_x > i_span_y;
        major   = x_major ? i_span_x : i_span_y;
        minor   = x_major ? i_span_y : i_span_x;

        // error scaled by 2*major; half a pixel equals major
        e_sum      = {i_err[COORD_BITS+1], i_err} + $signed({2'b00, minor, 1'b0});
        minor_step = e_sum >= $signed({3'b000, major});
        e_next     = minor_step ? (e_sum - $signed({2'b00, major, 1'b0})) : e_sum;
        o_err      = e_next[COORD_BITS+1:0];

        x_moved = i_x_down ? (i_cur_x - 1'b1) : (i_cur_x + 1'b1);
        y_moved = i_y_down ? (i_cur_y - 1'b1) : (i_cur_y + 1'b1);

        if (x_major) begin
            o_cur_x = x_moved;
            o_cur_y = minor_step ? y_moved : i_cur_y;
            o_done  = x_moved == i_tgt_x;
        end else begin
            o_cur_x = minor_step ? x_moved : i_cur_x;
            o_cur_y = y_moved;
            o_done  = y_moved == i_tgt_y;
        end
    end

endmodule
